/* hw/rtl/cpt_pkg.sv */
// Shared types, sizes and helpers for the contact pair table.
// No dependencies; imported by cpt_store and contact_pair_table.
`default_nettype none

package cpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] FN_PUT     = 2'd0;
    localparam logic [1:0] FN_DISCARD = 2'd1;
    localparam logic [1:0] FN_READ    = 2'd2;
    localparam logic [1:0] FN_CLEAR   = 2'd3;

    // contact payload kept per entry
    typedef struct packed {
        logic [47:0]        normal;
        logic signed [31:0] depth;
        logic [47:0]        point_a;
        logic [47:0]        point_b;
    } contact_t;

    // one table row: pair key {id_first, id_second} plus payload
    typedef struct packed {
        logic [31:0] key;
        contact_t    rec;
    } entry_t;

    // single write port, single registered read port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // |depth| with the most negative code saturated
    function automatic logic [30:0] mag_sat(input logic [31:0] d);
        logic [31:0] neg;
        neg = (~d) + 32'd1;
        if (d == 32'h8000_0000)
            mag_sat = 31'h7FFF_FFFF;
        else if (d[31])
            mag_sat = neg[30:0];
        else
            mag_sat = d[30:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cpt_store.sv */
// Entry storage for the contact pair table: one write, one registered read.
// Depends on cpt_pkg.
`default_nettype none

module cpt_store (
    input  wire logic              clk,
    input  wire cpt_pkg::mem_req_t req,
    input  wire cpt_pkg::entry_t   wr_data,
    output cpt_pkg::entry_t        rd_data
);
    import cpt_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= wr_data;
        end
        if (req.re)
        begin
            rd_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

/* hw/rtl/contact_pair_table.sv */
// Contact pair table top level: sequencer, occupancy and result registers.
// Depends on cpt_pkg and cpt_store.
`default_nettype none

// Usage
//   Command channel: drive func and the payload with start high; the beat is
//   taken on a rising edge where start is high and busy is low. busy stays
//   high until the result beat has been produced.
//   Result channel: done pulses for one cycle with all result ports valid.
//   The receiver must take it then; there is no way to hold it off.
// Sequence (n = entries held, p = position of the matching pair)
//   clear : result in the cycle after the command beat.
//   read  : in range, store read then RDW; out of range, result in the cycle after.
//   put / discard miss : LOOK and CMP for each of the n rows, then a last LOOK.
//   put hit            : LOOK and CMP up to row p; the hitting CMP ends it.
//   discard hit        : as put hit, then SH_RD and SH_WR per row after p (gap close).
//   The search walks the entry store a row at a time (read in LOOK, then
//   compare in CMP), and the gap close moves each later row down one place
//   (read in SH_RD, write in SH_WR) through the same store.
// Reset
//   rst_n clears the sequencer and the entry count, so the table is empty.
//   Store contents are not cleared; rows at or above the count are never read.
// A new command may be issued in the cycle done is high.

module contact_pair_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         func,
    input  wire logic [15:0]        id_first,
    input  wire logic [15:0]        id_second,
    input  wire logic [5:0]         entry_index,
    input  wire logic [47:0]        normal_in,
    input  wire logic signed [31:0] depth_in,
    input  wire logic [47:0]        point_a_in,
    input  wire logic [47:0]        point_b_in,
    output logic                    done,
    output logic                    pair_found,
    output logic                    record_written,
    output logic                    table_full_drop,
    output logic                    index_valid,
    output logic [6:0]              entry_count,
    output logic [15:0]             id_first_out,
    output logic [15:0]             id_second_out,
    output logic [47:0]             normal_out,
    output logic signed [31:0]      depth_out,
    output logic [47:0]             point_a_out,
    output logic [47:0]             point_b_out
);
    import cpt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;   // end check, issue key read
    localparam logic [2:0] ST_CMP   = 3'd2;   // compare key, act on a hit
    localparam logic [2:0] ST_SH_RD = 3'd3;   // read row scan+1
    localparam logic [2:0] ST_SH_WR = 3'd4;   // write it to row scan
    localparam logic [2:0] ST_RDW   = 3'd5;   // read data returning

    typedef struct packed {
        logic   found;
        logic   written;
        logic   drop;
        logic   ivalid;
        entry_t data;
    } result_t;

    // scan runs one past the last row so a full-table miss ends the search
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  scan_reg,  scan_next;
    logic [CNT_W-1:0]  occ_reg,   occ_next;
    logic [1:0]        func_reg,  func_next;
    logic [31:0]       key_reg,   key_next;
    contact_t          rec_reg,   rec_next;
    logic              done_reg,  done_next;
    result_t           res_reg,   res_next;

    mem_req_t mreq;
    entry_t   wdata;
    entry_t   rdata;

    cpt_store u_store (
        .clk     (clk),
        .req     (mreq),
        .wr_data (wdata),
        .rd_data (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        occ_next   = occ_reg;
        func_next  = func_reg;
        key_next   = key_reg;
        rec_next   = rec_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mreq       = '0;
        wdata      = {key_reg, rec_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next       = func;
                    key_next        = {id_first, id_second};
                    rec_next.normal  = normal_in;
                    rec_next.depth   = depth_in;
                    rec_next.point_a = point_a_in;
                    rec_next.point_b = point_b_in;
                    scan_next       = '0;
                    case (func)
                        FN_PUT, FN_DISCARD:
                        begin
                            state_next = ST_LOOK;
                        end
                        FN_READ:
                        begin
                            if (32'(entry_index) < 32'(occ_reg))
                            begin
                                mreq.re    = 1'b1;
                                mreq.raddr = ADDR_W'(entry_index);
                                state_next = ST_RDW;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                res_next  = '0;
                            end
                        end
                        default:   // clear
                        begin
                            occ_next  = '0;
                            done_next = 1'b1;
                            res_next  = '0;
                        end
                    endcase
                end
            end

            ST_LOOK:
            begin
                if (scan_reg == occ_reg)
                begin
                    // pair not held
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (func_reg == FN_PUT)
                    begin
                        if (occ_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            mreq.we          = 1'b1;
                            mreq.waddr       = ADDR_W'(occ_reg);
                            occ_next         = occ_reg + 1'b1;
                            res_next.written = 1'b1;
                        end
                        else
                        begin
                            res_next.drop = 1'b1;
                        end
                    end
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = ADDR_W'(scan_reg);
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (rdata.key == key_reg)
                begin
                    res_next       = '0;
                    res_next.found = 1'b1;
                    if (func_reg == FN_PUT)
                    begin
                        if (mag_sat(rdata.rec.depth) < mag_sat(rec_reg.depth))
                        begin
                            mreq.we          = 1'b1;
                            mreq.waddr       = ADDR_W'(scan_reg);
                            res_next.written = 1'b1;
                        end
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (scan_reg + 1'b1 < occ_reg)
                    begin
                        state_next = ST_SH_RD;
                    end
                    else
                    begin
                        occ_next   = occ_reg - 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_LOOK;
                end
            end

            ST_SH_RD:
            begin
                mreq.re    = 1'b1;
                mreq.raddr = ADDR_W'(scan_reg + 1'b1);
                state_next = ST_SH_WR;
            end

            ST_SH_WR:
            begin
                mreq.we   = 1'b1;
                mreq.waddr = ADDR_W'(scan_reg);
                wdata     = rdata;
                scan_next = scan_reg + 1'b1;
                if (scan_reg + 2'd2 < occ_reg)
                begin
                    state_next = ST_SH_RD;
                end
                else
                begin
                    occ_next   = occ_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_RDW:
            begin
                res_next        = '0;
                res_next.ivalid = 1'b1;
                res_next.data   = rdata;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        func_reg <= func_next;
        key_reg  <= key_next;
        rec_reg  <= rec_next;
        res_reg  <= res_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign pair_found      = res_reg.found;
    assign record_written  = res_reg.written;
    assign table_full_drop = res_reg.drop;
    assign index_valid     = res_reg.ivalid;
    assign entry_count     = 7'(occ_reg);
    assign id_first_out    = res_reg.data.key[31:16];
    assign id_second_out   = res_reg.data.key[15:0];
    assign normal_out      = res_reg.data.rec.normal;
    assign depth_out       = res_reg.data.rec.depth;
    assign point_a_out     = res_reg.data.rec.point_a;
    assign point_b_out     = res_reg.data.rec.point_b;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.we |-> (state_reg != ST_IDLE) && (state_reg != ST_RDW))
        else $error("store written outside a put or gap close");

    a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.drop) |->
            (!res_reg.found && !res_reg.written && occ_reg == CNT_W'(TABLE_DEPTH)))
        else $error("drop reported while the table had room or with a hit");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SH_RD) |-> (scan_reg + 1'b1 < occ_reg))
        else $error("gap close read beyond held entries");
`endif

endmodule

`default_nettype wire
